// File: hw/rtl/stroke_line_rasterizer_macros.svh
// Assertion shorthands used by the checker file slr_checker.sv.
// Each macro expects the clock aclk and the active-low reset aresetn in scope.
`ifndef STROKE_LINE_RASTERIZER_MACROS_SVH
`define STROKE_LINE_RASTERIZER_MACROS_SVH

// Same-cycle implication.
`define SLR_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error("stroke line rasterizer check failed");

// Next-cycle implication.
`define SLR_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error("stroke line rasterizer check failed");

`endif

// File: hw/rtl/slr_pkg.sv
package slr_pkg;

    // Raster geometry: RASTER_SIZE by RASTER_SIZE pixels, 6-bit pixel fields.
    localparam int RASTER_SIZE = 64;
    localparam int PIX_W       = 6;
    localparam logic [PIX_W-1:0] RASTER_MAX = PIX_W'(RASTER_SIZE - 1);

    // Field widths.
    localparam int COORD_W = 12;
    localparam int SCALE_W = 16;
    localparam int FRAC_W  = 12;
    localparam int PROD_W  = COORD_W + SCALE_W;
    localparam int ERR_W   = PIX_W + 3;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Register reset values.
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd4096;
    localparam logic [COORD_W-1:0] AREA_RESET  = 12'd63;

    // Input item kinds.
    typedef enum logic [0:0] {
        OP_BEGIN = 1'b0,
        OP_MOVE  = 1'b1
    } slr_op_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE_X     = 2'd0,
        REG_SCALE_Y     = 2'd1,
        REG_AREA_WIDTH  = 2'd2,
        REG_AREA_HEIGHT = 2'd3
    } slr_reg_t;

    // Which coordinate the shared multiplier works on.
    typedef enum logic [1:0] {
        SEL_OLD_X = 2'd0,
        SEL_OLD_Y = 2'd1,
        SEL_NEW_X = 2'd2,
        SEL_NEW_Y = 2'd3
    } slr_sel_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCALE = 2'd1,
        ST_SETUP = 2'd2,
        ST_STEP  = 2'd3
    } slr_state_t;

    // Control toward the scaling unit.
    typedef struct packed {
        logic     issue;
        slr_sel_t sel;
    } slr_scale_ctl_t;

    // Control toward the line stepper.
    typedef struct packed {
        logic setup;
        logic advance;
    } slr_step_ctl_t;

endpackage

// File: hw/rtl/slr_scaler.sv
// Shared multiplier: converts one area coordinate per cycle to a raster coordinate.
// The product is registered, then truncated, saturated and stored in the cycle after.
module slr_scaler (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  slr_pkg::slr_scale_ctl_t ctl,
    input  logic [11:0]            old_x,
    input  logic [11:0]            old_y,
    input  logic [11:0]            new_x,
    input  logic [11:0]            new_y,
    input  logic [15:0]            scale_x,
    input  logic [15:0]            scale_y,
    output logic [5:0]             x0,
    output logic [5:0]             y0,
    output logic [5:0]             x1,
    output logic [5:0]             y1
);
    import slr_pkg::*;

    logic [COORD_W-1:0]     coord_mux;
    logic [SCALE_W-1:0]     scale_mux;
    logic [PROD_W-1:0]      prod_reg;
    logic [PROD_W-1:0]      prod_next;
    logic                   prod_vld_reg;
    slr_sel_t               prod_sel_reg;
    logic [PROD_W-FRAC_W-1:0] whole;
    logic [PIX_W-1:0]       sat;
    logic [PIX_W-1:0]       res_reg [4];

    // Operand selection for the single multiplier.
    always_comb begin
        case (ctl.sel)
            SEL_OLD_X: begin
                coord_mux = old_x;
                scale_mux = scale_x;
            end
            SEL_OLD_Y: begin
                coord_mux = old_y;
                scale_mux = scale_y;
            end
            SEL_NEW_X: begin
                coord_mux = new_x;
                scale_mux = scale_x;
            end
            SEL_NEW_Y: begin
                coord_mux = new_y;
                scale_mux = scale_y;
            end
            default: begin
                coord_mux = old_x;
                scale_mux = scale_x;
            end
        endcase
    end

    assign prod_next = PROD_W'(coord_mux) * PROD_W'(scale_mux);

    // Product stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= ctl.issue;
        end
        prod_reg     <= prod_next;
        prod_sel_reg <= ctl.sel;
    end

    // Drop the fraction and clamp to the raster edge.
    assign whole = prod_reg[PROD_W-1:FRAC_W];
    assign sat   = (whole > (PROD_W-FRAC_W)'(RASTER_MAX)) ? RASTER_MAX : whole[PIX_W-1:0];

    // Result store, one slot per coordinate.
    always_ff @(posedge aclk) begin
        if (prod_vld_reg) begin
            res_reg[prod_sel_reg] <= sat;
        end
    end

    assign x0 = res_reg[SEL_OLD_X];
    assign y0 = res_reg[SEL_OLD_Y];
    assign x1 = res_reg[SEL_NEW_X];
    assign y1 = res_reg[SEL_NEW_Y];

endmodule

// File: hw/rtl/slr_stepper.sv
// Bresenham stepper: one shared add and compare on the error term per pixel.
// Coordinates are kept as major and minor axes so one datapath serves both slopes.
module slr_stepper (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  slr_pkg::slr_step_ctl_t ctl,
    input  logic [5:0]            x0,
    input  logic [5:0]            y0,
    input  logic [5:0]            x1,
    input  logic [5:0]            y1,
    output logic [5:0]            pix_x,
    output logic [5:0]            pix_y,
    output logic                  at_end
);
    import slr_pkg::*;

    logic [PIX_W-1:0]        adx;
    logic [PIX_W-1:0]        ady;
    logic                    x_pos;
    logic                    y_pos;
    logic                    x_major;
    logic [PIX_W-1:0]        dmaj;
    logic [PIX_W-1:0]        dmin;
    logic signed [ERR_W-1:0] err_init;
    logic                    take_minor;
    logic signed [ERR_W-1:0] err_step;

    logic                    x_major_reg;
    logic                    maj_pos_reg;
    logic                    min_pos_reg;
    logic [PIX_W-1:0]        maj_reg;
    logic [PIX_W-1:0]        min_reg;
    logic [PIX_W-1:0]        maj_end_reg;
    logic [PIX_W:0]          dmaj2_reg;
    logic [PIX_W:0]          dmin2_reg;
    logic signed [ERR_W-1:0] err_reg;

    // Line setup from the scaled end points.
    always_comb begin
        x_pos    = x1 > x0;
        y_pos    = y1 > y0;
        adx      = x_pos ? (x1 - x0) : (x0 - x1);
        ady      = y_pos ? (y1 - y0) : (y0 - y1);
        x_major  = adx >= ady;
        dmaj     = x_major ? adx : ady;
        dmin     = x_major ? ady : adx;
        err_init = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
    end

    // One error update: the minor axis moves on a positive error, or on zero
    // error when the major axis runs upward.
    always_comb begin
        take_minor = (err_reg > 0) || ((err_reg == 0) && maj_pos_reg);
        if (take_minor) begin
            err_step = err_reg - $signed({2'b00, dmaj2_reg}) + $signed({2'b00, dmin2_reg});
        end else begin
            err_step = err_reg + $signed({2'b00, dmin2_reg});
        end
    end

    // Line state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_major_reg <= 1'b1;
        end else if (ctl.setup) begin
            x_major_reg <= x_major;
        end
        if (ctl.setup) begin
            maj_pos_reg <= x_major ? x_pos : y_pos;
            min_pos_reg <= x_major ? y_pos : x_pos;
            maj_reg     <= x_major ? x0 : y0;
            min_reg     <= x_major ? y0 : x0;
            maj_end_reg <= x_major ? x1 : y1;
            dmaj2_reg   <= {dmaj, 1'b0};
            dmin2_reg   <= {dmin, 1'b0};
            err_reg     <= err_init;
        end else if (ctl.advance) begin
            err_reg <= err_step;
            maj_reg <= maj_pos_reg ? (maj_reg + 1'b1) : (maj_reg - 1'b1);
            if (take_minor) begin
                min_reg <= min_pos_reg ? (min_reg + 1'b1) : (min_reg - 1'b1);
            end
        end
    end

    assign pix_x  = x_major_reg ? maj_reg : min_reg;
    assign pix_y  = x_major_reg ? min_reg : maj_reg;
    assign at_end = maj_reg == maj_end_reg;

endmodule

// File: hw/rtl/stroke_line_rasterizer.sv
// Channel   Direction  Word contents (low bit first)
// s_axis    in         tdata: point_x[11:0], point_y[23:12]; tuser: opcode
// m_axis    out        tdata: pixel_x[5:0], pixel_y[11:6], zeros; tlast: last_pixel
// cfg       in         write enable, index, data (no read-back)
//
// A begin word or a point outside the draw area starts no line; the sequencer stays idle.
// A move is accepted while idle, then its four coordinates pass through the
// shared multiplier, one per cycle, followed by its output stage; the line is
// set up, and the Bresenham stepper gives one pixel per cycle unless m_axis stalls.
// Reset (aresetn, synchronous) clears the sequencer, registers and stored point.
// A stall on m_axis holds the stepper; s_tready is high only while idle.
module stroke_line_rasterizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // point_x[11:0], point_y[23:12]
    input  logic [0:0]  s_tuser,   // opcode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // pixel_x[5:0], pixel_y[11:6], zero pad
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import slr_pkg::*;

    slr_state_t         state_reg;
    slr_state_t         state_next;
    logic [2:0]         cnt_reg;
    logic [2:0]         cnt_next;

    logic [SCALE_W-1:0] scale_x_reg;
    logic [SCALE_W-1:0] scale_y_reg;
    logic [COORD_W-1:0] area_w_reg;
    logic [COORD_W-1:0] area_h_reg;
    logic [COORD_W-1:0] prev_x_reg;
    logic [COORD_W-1:0] prev_y_reg;
    logic [COORD_W-1:0] old_x_reg;
    logic [COORD_W-1:0] old_y_reg;
    logic [COORD_W-1:0] new_x_reg;
    logic [COORD_W-1:0] new_y_reg;

    logic [COORD_W-1:0] in_x;
    logic [COORD_W-1:0] in_y;
    slr_op_t            in_op;
    logic               in_acc;
    logic               in_area;

    slr_scale_ctl_t     scl_ctl;
    slr_step_ctl_t      stp_ctl;
    logic               out_load;
    logic [PIX_W-1:0]   x0;
    logic [PIX_W-1:0]   y0;
    logic [PIX_W-1:0]   x1;
    logic [PIX_W-1:0]   y1;
    logic [PIX_W-1:0]   pix_x;
    logic [PIX_W-1:0]   pix_y;
    logic               at_end;

    logic               m_valid_reg;
    logic [PIX_W-1:0]   m_x_reg;
    logic [PIX_W-1:0]   m_y_reg;
    logic               m_last_reg;

    // Input word unpacking and area check.
    assign in_x    = s_tdata[COORD_W-1:0];
    assign in_y    = s_tdata[2*COORD_W-1:COORD_W];
    assign in_op   = slr_op_t'(s_tuser[0]);
    assign in_acc  = s_tvalid && s_tready;
    assign in_area = (in_x <= area_w_reg) && (in_y <= area_h_reg);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_x_reg <= SCALE_RESET;
            scale_y_reg <= SCALE_RESET;
            area_w_reg  <= AREA_RESET;
            area_h_reg  <= AREA_RESET;
        end else if (cfg_wr_en) begin
            case (slr_reg_t'(cfg_index))
                REG_SCALE_X:     scale_x_reg <= cfg_wdata;
                REG_SCALE_Y:     scale_y_reg <= cfg_wdata;
                REG_AREA_WIDTH:  area_w_reg  <= cfg_wdata[COORD_W-1:0];
                REG_AREA_HEIGHT: area_h_reg  <= cfg_wdata[COORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Stored stroke point and the end points of the line in progress.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
        end else if (in_acc && in_area) begin
            prev_x_reg <= in_x;
            prev_y_reg <= in_y;
        end
        if (in_acc && in_area && (in_op == OP_MOVE)) begin
            old_x_reg <= prev_x_reg;
            old_y_reg <= prev_y_reg;
            new_x_reg <= in_x;
            new_y_reg <= in_y;
        end
    end

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (in_acc && in_area && (in_op == OP_MOVE)) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd4) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                state_next = ST_STEP;
            end
            ST_STEP: begin
                if (out_load && at_end) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready        = 1'b0;
        scl_ctl.issue   = 1'b0;
        scl_ctl.sel     = slr_sel_t'(cnt_reg[1:0]);
        stp_ctl.setup   = 1'b0;
        stp_ctl.advance = 1'b0;
        out_load        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_SCALE: begin
                scl_ctl.issue = !cnt_reg[2];
            end
            ST_SETUP: begin
                stp_ctl.setup = 1'b1;
            end
            ST_STEP: begin
                out_load        = !m_valid_reg || m_tready;
                stp_ctl.advance = out_load && !at_end;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    slr_scaler u_scaler (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (scl_ctl),
        .old_x   (old_x_reg),
        .old_y   (old_y_reg),
        .new_x   (new_x_reg),
        .new_y   (new_y_reg),
        .scale_x (scale_x_reg),
        .scale_y (scale_y_reg),
        .x0      (x0),
        .y0      (y0),
        .x1      (x1),
        .y1      (y1)
    );

    slr_stepper u_stepper (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (stp_ctl),
        .x0      (x0),
        .y0      (y0),
        .x1      (x1),
        .y1      (y1),
        .pix_x   (pix_x),
        .pix_y   (pix_y),
        .at_end  (at_end)
    );

    // Output register between the stepper and the result channel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            m_x_reg    <= pix_x;
            m_y_reg    <= pix_y;
            m_last_reg <= at_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - 2*PIX_W)'(0), m_y_reg, m_x_reg};
    assign m_tlast  = m_last_reg;

endmodule

// File: hw/rtl/slr_checker.sv
`include "stroke_line_rasterizer_macros.svh"

// Port-level checks for the stroke line rasterizer.
module slr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);
    import slr_pkg::*;

    // A stalled pixel word holds its contents.
    `SLR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // While a line is still being drawn the input side stays closed.
    `SLR_ASSERT_NOW(a_busy_in_line, m_tvalid && !m_tlast, !s_tready)

    // A begin word never starts the line sequencer.
    `SLR_ASSERT_NEXT(a_begin_free, s_tvalid && s_tready && (s_tuser[0] == OP_BEGIN), s_tready)

    // Pixels lie on the raster.
    `SLR_ASSERT_NOW(a_on_raster, m_tvalid, (m_tdata[5:0] <= RASTER_MAX) && (m_tdata[11:6] <= RASTER_MAX))

endmodule

bind stroke_line_rasterizer slr_checker u_slr_checker (.*);
